/* hw/rtl/sbm_pkg.sv */
// Shared types and constants for the serial bank mapper with IRQ timer.
// Used by sbm_loader, sbm_regs, the top level and the port checker.
`timescale 1ns / 1ps

package sbm_pkg;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // Serial loader targets, taken from address bits 14:13.
    typedef enum logic [1:0] {
        TGT_CONTROL = 2'd0,
        TGT_BANK    = 2'd1,
        TGT_CHR     = 2'd2,
        TGT_PRG     = 2'd3
    } target_t;

    localparam logic [15:0] ADDR_IRQ_STATUS = 16'h40A2;
    localparam logic [15:0] ADDR_IRQ_LOW    = 16'h40A6;
    localparam logic [15:0] ADDR_IRQ_HIGH   = 16'h40A7;
    localparam logic [15:0] ADDR_IRQ_ENABLE = 16'h40A8;
    localparam logic [15:0] ADDR_READ_ZERO  = 16'h40AC;
    localparam logic [15:0] ADDR_GLYPH_RST  = 16'h40B0;
    localparam logic [15:0] ADDR_MISC       = 16'h40C0;

    localparam logic [4:0] CONTROL_RESET = 5'h1F;
    localparam logic [7:0] MISC_RESET    = 8'hC0;
    localparam logic [7:0] READ_OPEN     = 8'hFF;
    localparam logic [1:0] GUARD_LOAD    = 2'd2;
    localparam int         SHIFT_BITS    = 5;

    // Widths of the stream ports.
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 48;
    localparam int M_USER_W = 2;

    // One decoded item, already qualified by the pipeline advance.
    typedef struct packed {
        logic        serial_wr;
        logic        reg_wr;
        logic        reg_rd;
        logic        glyph_rd;
        logic        tick;
        logic [15:0] address;
        logic [7:0]  data;
        logic [7:0]  cycles;
    } cmd_t;

    typedef struct packed {
        logic [4:0] prg_bank_low;
        logic [4:0] prg_bank_high;
        logic [1:0] wram_bank;
        logic [1:0] mirroring;
    } bank_view_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        read_handled;
        logic [16:0] kanji_rom_address;
        logic        kanji_address_valid;
        logic        irq_line;
        logic        chr_bank;
    } reg_view_t;

endpackage

/* hw/rtl/sbm_loader.sv */
// Serial shift loader, reset guard and bank registers with PRG bank mapping.
// Depends on sbm_pkg for cmd_t, bank_view_t and the loader constants.
`timescale 1ns / 1ps

module sbm_loader
    import sbm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cmd_t       cmd,
    output bank_view_t banks
);

    logic [4:0] control_reg, control_next;
    logic [4:0] bank_reg, bank_next;
    logic [4:0] prg_reg, prg_next;
    logic [4:0] shift_value_reg, shift_value_next;
    logic [2:0] shift_count_reg, shift_count_next;
    logic [1:0] guard_reg, guard_next;
    logic [4:0] shifted;
    logic       bank_hi;
    logic [3:0] prg_sel;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            control_reg     <= CONTROL_RESET;
            bank_reg        <= '0;
            prg_reg         <= '0;
            shift_value_reg <= '0;
            shift_count_reg <= '0;
            guard_reg       <= '0;
        end else begin
            control_reg     <= control_next;
            bank_reg        <= bank_next;
            prg_reg         <= prg_next;
            shift_value_reg <= shift_value_next;
            shift_count_reg <= shift_count_next;
            guard_reg       <= guard_next;
        end
    end

    always_comb begin
        control_next     = control_reg;
        bank_next        = bank_reg;
        prg_next         = prg_reg;
        shift_value_next = shift_value_reg;
        shift_count_next = shift_count_reg;
        guard_next       = guard_reg;
        shifted          = shift_value_reg | (5'(cmd.data[0]) << shift_count_reg);

        if (cmd.serial_wr && (guard_reg == 2'd0)) begin
            if (cmd.data[7]) begin
                control_next     = control_reg | 5'h0C;
                shift_value_next = '0;
                shift_count_next = '0;
                guard_next       = GUARD_LOAD;
            end else if (shift_count_reg == 3'(SHIFT_BITS - 1)) begin
                // Fifth bit: commit to the register picked by the address.
                shift_value_next = '0;
                shift_count_next = '0;
                case (target_t'(cmd.address[14:13]))
                    TGT_CONTROL: control_next = shifted;
                    TGT_BANK:    bank_next    = shifted;
                    TGT_PRG:     prg_next     = shifted;
                    default:     ;
                endcase
            end else begin
                shift_value_next = shifted;
                shift_count_next = shift_count_reg + 3'd1;
            end
        end

        if (cmd.tick) begin
            if (cmd.cycles >= {6'd0, guard_reg}) begin
                guard_next = '0;
            end else begin
                guard_next = guard_reg - cmd.cycles[1:0];
            end
        end
    end

    // Bank outputs reflect the state after this item.
    assign bank_hi = bank_next[4];
    assign prg_sel = prg_next[3:0];

    always_comb begin
        case (control_next[3:2])
            2'd3: begin
                banks.prg_bank_low  = {bank_hi, prg_sel};
                banks.prg_bank_high = {bank_hi, 4'hF};
            end
            2'd2: begin
                banks.prg_bank_low  = {bank_hi, 4'h0};
                banks.prg_bank_high = {bank_hi, prg_sel};
            end
            default: begin
                banks.prg_bank_low  = {bank_hi, prg_sel[3:1], 1'b0};
                banks.prg_bank_high = {bank_hi, prg_sel[3:1], 1'b1};
            end
        endcase
        banks.wram_bank = bank_next[1:0];
        banks.mirroring = control_next[1:0];
    end

endmodule

/* hw/rtl/sbm_regs.sv */
// IRQ down-counter, status and clear-on-read registers, glyph address generator.
// Depends on sbm_pkg for cmd_t, reg_view_t and the register addresses.
`timescale 1ns / 1ps

module sbm_regs
    import sbm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cmd_t      cmd,
    output reg_view_t view
);

    logic [31:0] irq_counter_reg, irq_counter_next;
    logic [7:0]  irq_enable_reg, irq_enable_next;
    logic        irq_pending_reg, irq_pending_next;
    logic [7:0]  misc_status_reg, misc_status_next;
    logic        chr_latch_reg, chr_latch_next;
    logic [4:0]  glyph_reg, glyph_next;
    logic [32:0] diff;
    logic [31:0] sat_value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            irq_counter_reg <= '0;
            irq_enable_reg  <= '0;
            irq_pending_reg <= 1'b0;
            misc_status_reg <= MISC_RESET;
            chr_latch_reg   <= 1'b0;
            glyph_reg       <= '0;
        end else begin
            irq_counter_reg <= irq_counter_next;
            irq_enable_reg  <= irq_enable_next;
            irq_pending_reg <= irq_pending_next;
            misc_status_reg <= misc_status_next;
            chr_latch_reg   <= chr_latch_next;
            glyph_reg       <= glyph_next;
        end
    end

    // Signed subtract one bit wider; a borrow past the sign saturates at the minimum.
    assign diff = {irq_counter_reg[31], irq_counter_reg} - {25'd0, cmd.cycles};
    assign sat_value = (diff[32] != diff[31]) ? 32'h8000_0000 : diff[31:0];

    always_comb begin
        irq_counter_next = irq_counter_reg;
        irq_enable_next  = irq_enable_reg;
        irq_pending_next = irq_pending_reg;
        misc_status_next = misc_status_reg;
        chr_latch_next   = chr_latch_reg;
        glyph_next       = glyph_reg;

        view.read_data           = '0;
        view.read_handled        = 1'b0;
        view.kanji_rom_address   = '0;
        view.kanji_address_valid = 1'b0;

        if (cmd.reg_wr) begin
            case (cmd.address)
                ADDR_IRQ_LOW:    irq_counter_next = {16'd0, irq_counter_reg[15:8], cmd.data};
                ADDR_IRQ_HIGH:   irq_counter_next = {16'd0, cmd.data, irq_counter_reg[7:0]};
                ADDR_IRQ_ENABLE: irq_enable_next = cmd.data;
                ADDR_MISC: begin
                    misc_status_next = cmd.data;
                    chr_latch_next   = cmd.data[3];
                end
                default: ;
            endcase
        end

        if (cmd.reg_rd) begin
            view.read_handled = 1'b1;
            case (cmd.address)
                ADDR_IRQ_STATUS: begin
                    view.read_data   = irq_enable_reg >> 1;
                    irq_pending_next = 1'b0;
                    irq_enable_next  = '0;
                end
                ADDR_READ_ZERO: view.read_data = '0;
                ADDR_GLYPH_RST: begin
                    view.read_data = '0;
                    glyph_next     = '0;
                end
                ADDR_MISC: begin
                    view.read_data   = misc_status_reg;
                    misc_status_next = '0;
                end
                default: view.read_data = READ_OPEN;
            endcase
        end

        if (cmd.glyph_rd) begin
            // Each glyph is 32 bytes, so the position fills the low five bits.
            view.kanji_rom_address   = {cmd.address[11:0], glyph_reg};
            view.kanji_address_valid = 1'b1;
            glyph_next               = glyph_reg + 5'd1;
        end

        if (cmd.tick && (irq_enable_reg != 8'd0)) begin
            irq_counter_next = sat_value;
            if (sat_value[31] || (sat_value == 32'd0)) begin
                irq_pending_next = 1'b1;
            end
        end

        view.irq_line = irq_pending_next;
        view.chr_bank = chr_latch_next;
    end

endmodule

/* hw/rtl/serial_bank_mapper_with_irq_timer.sv */
// Top level: input register, address decode and result register around
// sbm_loader and sbm_regs. Depends on sbm_pkg.
`timescale 1ns / 1ps

// The block takes one CPU bus item (write, read or tick) per clock while
// the result side is not stalled, and returns one result item for each, in
// order. An accepted item sits in the input register, where the decode and
// all register updates are done as it moves on, and its result is then
// registered in the output register. The input stays open while a result
// waits, as long as the input register is free or moving on. The bank
// fields of each result show the mapper state after that item. No clearing
// pass runs after reset.
module serial_bank_mapper_with_irq_timer
    import sbm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // address[15:0], write_data[23:16], cycles[31:24]
    input  logic [S_DATA_W-1:0] s_tdata,
    // operation[1:0]
    input  logic [1:0]          s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // read_data[7:0], kanji_rom_address[24:8], irq_line[25], prg_bank_low[30:26],
    // prg_bank_high[35:31], wram_bank[37:36], chr_bank[38], mirroring[40:39], zeros
    output logic [M_DATA_W-1:0] m_tdata,
    // read_handled[0], kanji_address_valid[1]
    output logic [M_USER_W-1:0] m_tuser
);

    logic                in_valid_reg;
    op_t                 op_reg;
    logic [15:0]         address_reg;
    logic [7:0]          data_reg;
    logic [7:0]          cycles_reg;
    logic                advance;
    cmd_t                cmd;
    bank_view_t          banks;
    reg_view_t           view;
    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic [M_USER_W-1:0] out_user_reg;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg      <= op_t'(s_tuser);
            address_reg <= s_tdata[15:0];
            data_reg    <= s_tdata[23:16];
            cycles_reg  <= s_tdata[31:24];
        end
    end

    always_comb begin
        cmd.serial_wr = 1'b0;
        cmd.reg_wr    = 1'b0;
        cmd.reg_rd    = 1'b0;
        cmd.glyph_rd  = 1'b0;
        cmd.tick      = 1'b0;
        cmd.address   = address_reg;
        cmd.data      = data_reg;
        cmd.cycles    = cycles_reg;
        if (advance) begin
            case (op_reg)
                OP_WRITE: begin
                    cmd.serial_wr = address_reg[15];
                    cmd.reg_wr    = address_reg inside {[16'h4080:16'h40FF]};
                end
                OP_READ: begin
                    cmd.reg_rd   = address_reg inside {[16'h4080:16'h40FF]};
                    cmd.glyph_rd = address_reg inside {[16'h5000:16'h5FFF]};
                end
                OP_TICK: cmd.tick = 1'b1;
                default: ;
            endcase
        end
    end

    sbm_loader u_loader (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .banks   (banks)
    );

    sbm_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .view    (view)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {7'd0, banks.mirroring, view.chr_bank, banks.wram_bank,
                             banks.prg_bank_high, banks.prg_bank_low, view.irq_line,
                             view.kanji_rom_address, view.read_data};
            out_user_reg <= {view.kanji_address_valid, view.read_handled};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

/* hw/rtl/sbm_checker.sv */
// Port-level checks for serial_bank_mapper_with_irq_timer, bound to the top level.
// Depends on sbm_pkg for the port widths.
`timescale 1ns / 1ps

module sbm_checker
    import sbm_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [M_USER_W-1:0] m_tuser
);

    // A stalled result item keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    // A read is answered by the register window or the glyph window, never both.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("register answer and glyph address in one item");

    // Read data is zero unless the register window answered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[7:0] == 8'd0)
        else $error("read data on an unanswered item");

    // The glyph address is zero unless the item was a glyph read.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[1] |-> m_tdata[24:8] == 17'd0)
        else $error("glyph address on a non-glyph item");

    // Both program banks sit in the same half chosen by bank bit 4.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[35] == m_tdata[30])
        else $error("program banks in different outer halves");

endmodule

bind serial_bank_mapper_with_irq_timer sbm_checker u_sbm_checker (.*);
